/* hdl/prde_pkg.sv */
// Shared constants and types of the pair-rule dictionary encoder.
`default_nettype none

package prde_pkg;

    // Rule table geometry.
    localparam int TABLE_ENTRIES = 4096;
    localparam int SLOT_W        = $clog2(TABLE_ENTRIES);

    // Rule ids and keys.
    localparam int ID_BITS    = 24;
    localparam int FIELD_ID_W = 24;
    localparam int KEY_W      = 2 * ID_BITS + 1;
    localparam int NFID_W     = ID_BITS + 1;
    localparam int WORD_W     = 1 + KEY_W + ID_BITS;

    // Digit-serial hash: the key is multiplied by the golden-ratio constant
    // one digit per cycle, keeping only the product bits that reach the slot.
    localparam int DIGIT_W    = 16;
    localparam int HASH_STEPS = (KEY_W + DIGIT_W - 1) / DIGIT_W;
    localparam int HKEY_W     = HASH_STEPS * DIGIT_W;
    localparam int STEP_W     = (HASH_STEPS > 1) ? $clog2(HASH_STEPS) : 1;
    localparam int HASH_SHIFT = 32;
    localparam int PROD_W     = HASH_SHIFT + SLOT_W;
    localparam logic [63:0] GOLDEN = 64'h9E3779B97F4A7C15;
    localparam logic [PROD_W-1:0] HASH_C = GOLDEN[PROD_W-1:0];

    // Stream payload widths.
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 32;

    typedef enum logic [1:0] {
        ACT_UNARY   = 2'd0,
        ACT_BINARY  = 2'd1,
        ACT_RESERVE = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_FULL      = 2'd1,
        STAT_EXHAUSTED = 2'd2
    } status_t;

    typedef enum logic {
        KIND_RECORD = 1'b0,
        KIND_NODE   = 1'b1
    } kind_t;

endpackage

`default_nettype wire

/* hdl/prde_ram.sv */
// Generic simple dual-port RAM with a registered read.
`default_nettype none

module prde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write and one registered read per cycle.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/pair_rule_dictionary_encoder_core.sv */
// Pair-rule dictionary encoder: rule table probe, insert and result emission.
//
// Each node is looked up in a linear-probing hash table held in one RAM
// (valid bit, key and id per entry). After reset a clearing pass writes every
// entry invalid, one per cycle, before the first transfer is accepted;
// configuration writes are taken throughout. A node is accepted, hashed in
// four digit-serial steps and probed in a read state and then a compare state
// per probe, followed by one result per cycle while the output is not stalled;
// each further probe of a collision chain repeats the read and compare. A
// reservation goes straight from acceptance to emission. The output register
// lets the next node be accepted while the last result of the previous one
// still waits to be taken.
`default_nettype none

module pair_rule_dictionary_encoder_core (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // Configuration: start_id.
    input  wire logic                            cfg_we,
    input  wire logic [prde_pkg::FIELD_ID_W-1:0] cfg_wdata,
    // Input stream.
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // tdata: left_id[23:0], left_is_copy[24], left_is_binary[25],
    //        right_id[49:26], right_is_copy[50], right_is_binary[51], zero pad
    input  wire logic [prde_pkg::S_TDATA_W-1:0]  s_tdata,
    // tuser: action[1:0]
    input  wire logic [1:0]                      s_tuser,
    // Result stream.
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // tdata: copy_bit[0], tree_bit[1], symbol_id[25:2], status[27:26], zero pad
    output logic [prde_pkg::M_TDATA_W-1:0]       m_tdata,
    // tuser: kind[0]
    output logic                                 m_tuser,
    output logic                                 m_tlast
);

    import prde_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH,
        ST_READ,
        ST_CHECK,
        ST_EMIT
    } state_t;

    state_t                  state_reg;
    logic [SLOT_W-1:0]       clr_reg;
    logic [NFID_W-1:0]       nfid_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [HKEY_W-1:0]       hkey_reg;
    logic [PROD_W-1:0]       acc_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [SLOT_W-1:0]       pos_reg;
    logic [SLOT_W:0]         probe_reg;
    logic                    bin_reg;
    logic [ID_BITS-1:0]      lid_reg;
    logic [ID_BITS-1:0]      rid_reg;
    logic                    lcopy_reg, lbin_reg, rcopy_reg, rbin_reg;
    logic [1:0]              rec_n_reg;
    logic [1:0]              idx_reg;
    logic                    node_copy_reg;
    logic [ID_BITS-1:0]      node_id_reg;
    status_t                 node_stat_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;
    logic                    m_tuser_reg;
    logic                    m_tlast_reg;

    logic [DIGIT_W-1:0]      digit;
    logic [PROD_W-1:0]       hash_part;
    logic [PROD_W-1:0]       acc_next;
    logic [ID_BITS-1:0]      in_lid, in_rid;
    logic [KEY_W-1:0]        in_key;
    logic                    in_bin;
    logic                    out_free;
    logic [WORD_W-1:0]       rd_data;
    logic                    rd_valid;
    logic [KEY_W-1:0]        rd_key;
    logic [ID_BITS-1:0]      rd_val;
    logic                    hit, miss_free, exhausted, table_full, insert;
    logic                    ram_we;
    logic [SLOT_W-1:0]       ram_waddr;
    logic [WORD_W-1:0]       ram_wdata;
    logic                    item_kind, item_copy, item_tree, item_last;
    logic [FIELD_ID_W-1:0]   item_id;
    status_t                 item_stat;
    logic                    rec_copy, rec_bin;
    logic [ID_BITS-1:0]      rec_id;
    logic [31:0]             cfg_ext;

    // Rule key of the incoming node.
    always_comb begin
        in_lid = ID_BITS'(s_tdata[23:0]);
        in_rid = ID_BITS'(s_tdata[49:26]);
        in_bin = (s_tuser == ACT_BINARY);
        in_key = {in_lid, in_bin ? (NFID_W'(in_rid) + NFID_W'(1)) : NFID_W'(0)};
    end

    // One hash digit: partial product shifted into place and accumulated.
    always_comb begin
        digit     = hkey_reg[DIGIT_W-1:0];
        hash_part = PROD_W'(digit * HASH_C);
        acc_next  = acc_reg + (hash_part << (step_reg * DIGIT_W));
    end

    // Probe decision on the entry that was read last cycle.
    always_comb begin
        rd_valid   = rd_data[WORD_W-1];
        rd_key     = rd_data[ID_BITS +: KEY_W];
        rd_val     = rd_data[ID_BITS-1:0];
        hit        = rd_valid && (rd_key == key_reg);
        miss_free  = !rd_valid;
        table_full = rd_valid && !hit && (probe_reg == (SLOT_W + 1)'(TABLE_ENTRIES - 1));
        exhausted  = nfid_reg[ID_BITS];
        insert     = (state_reg == ST_CHECK) && miss_free && !exhausted;
    end

    // RAM write port: clearing pass or rule insertion.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = pos_reg;
        ram_wdata = {1'b1, key_reg, nfid_reg[ID_BITS-1:0]};
        if (state_reg == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = clr_reg;
            ram_wdata = '0;
        end else if (insert) begin
            ram_we = 1'b1;
        end
    end

    prde_ram #(
        .WIDTH(WORD_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_table (
        .aclk   (aclk),
        .wr_en  (ram_we),
        .wr_addr(ram_waddr),
        .wr_data(ram_wdata),
        .rd_en  (state_reg == ST_READ),
        .rd_addr(pos_reg),
        .rd_data(rd_data)
    );

    // Result item selected by the emission index: child records, then node.
    always_comb begin
        rec_copy  = (idx_reg == 2'd0) ? lcopy_reg : rcopy_reg;
        rec_bin   = (idx_reg == 2'd0) ? lbin_reg : rbin_reg;
        rec_id    = (idx_reg == 2'd0) ? lid_reg : rid_reg;
        if (idx_reg < rec_n_reg) begin
            item_kind = KIND_RECORD;
            item_copy = rec_copy;
            item_tree = rec_copy ? 1'b0 : rec_bin;
            item_id   = rec_copy ? FIELD_ID_W'(rec_id) : '0;
            item_stat = STAT_OK;
            item_last = 1'b0;
        end else begin
            item_kind = KIND_NODE;
            item_copy = node_copy_reg;
            item_tree = bin_reg;
            item_id   = FIELD_ID_W'(node_id_reg);
            item_stat = node_stat_reg;
            item_last = 1'b1;
        end
    end

    assign out_free = !m_tvalid_reg || m_tready;
    assign cfg_ext  = 32'(cfg_wdata);

    // Sequencer: clearing pass, hashing, probing, insertion and emission.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            clr_reg      <= '0;
            nfid_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            // The emission state reloads the output register itself.
            if (m_tvalid_reg && m_tready && (state_reg != ST_EMIT)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + SLOT_W'(1);
                    if (clr_reg == SLOT_W'(TABLE_ENTRIES - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_tvalid) begin
                        lid_reg       <= in_lid;
                        rid_reg       <= in_rid;
                        lcopy_reg     <= s_tdata[24];
                        lbin_reg      <= s_tdata[25];
                        rcopy_reg     <= s_tdata[50];
                        rbin_reg      <= s_tdata[51];
                        bin_reg       <= in_bin;
                        key_reg       <= in_key;
                        hkey_reg      <= HKEY_W'(in_key);
                        acc_reg       <= '0;
                        step_reg      <= '0;
                        probe_reg     <= '0;
                        idx_reg       <= '0;
                        rec_n_reg     <= '0;
                        node_copy_reg <= 1'b0;
                        case (s_tuser)
                            ACT_UNARY, ACT_BINARY: begin
                                state_reg <= ST_HASH;
                            end
                            ACT_RESERVE: begin
                                if (nfid_reg[ID_BITS]) begin
                                    node_id_reg   <= '0;
                                    node_stat_reg <= STAT_EXHAUSTED;
                                end else begin
                                    node_id_reg   <= nfid_reg[ID_BITS-1:0];
                                    node_stat_reg <= STAT_OK;
                                    if (!cfg_we) begin
                                        nfid_reg <= nfid_reg + NFID_W'(1);
                                    end
                                end
                                state_reg <= ST_EMIT;
                            end
                            default: begin
                                state_reg <= ST_IDLE;
                            end
                        endcase
                    end
                end
                ST_HASH: begin
                    acc_reg  <= acc_next;
                    hkey_reg <= hkey_reg >> DIGIT_W;
                    step_reg <= step_reg + STEP_W'(1);
                    if (step_reg == STEP_W'(HASH_STEPS - 1)) begin
                        pos_reg   <= acc_next[HASH_SHIFT +: SLOT_W];
                        state_reg <= ST_READ;
                    end
                end
                ST_READ: begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK: begin
                    if (hit) begin
                        node_copy_reg <= 1'b1;
                        node_id_reg   <= rd_val;
                        node_stat_reg <= STAT_OK;
                        state_reg     <= ST_EMIT;
                    end else if (table_full) begin
                        node_id_reg   <= '0;
                        node_stat_reg <= STAT_FULL;
                        state_reg     <= ST_EMIT;
                    end else if (miss_free) begin
                        if (exhausted) begin
                            node_id_reg   <= '0;
                            node_stat_reg <= STAT_EXHAUSTED;
                        end else begin
                            node_id_reg   <= nfid_reg[ID_BITS-1:0];
                            node_stat_reg <= STAT_OK;
                            if (!cfg_we) begin
                                nfid_reg <= nfid_reg + NFID_W'(1);
                            end
                            rec_n_reg     <= bin_reg ? 2'd2 : 2'd1;
                        end
                        state_reg <= ST_EMIT;
                    end else begin
                        pos_reg   <= pos_reg + SLOT_W'(1);
                        probe_reg <= probe_reg + (SLOT_W + 1)'(1);
                        state_reg <= ST_READ;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({item_stat, item_id, item_tree, item_copy});
                        m_tuser_reg  <= item_kind;
                        m_tlast_reg  <= item_last;
                        idx_reg      <= idx_reg + 2'd1;
                        if (item_last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
            // A start_id write also reloads the id counter, saturating at the limit.
            if (cfg_we) begin
                if (cfg_ext >= (32'd1 << ID_BITS)) begin
                    nfid_reg <= NFID_W'(1) << ID_BITS;
                end else begin
                    nfid_reg <= NFID_W'(cfg_ext);
                end
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // The id counter never passes the exhaustion limit.
    a_nfid_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        nfid_reg <= (NFID_W'(1) << ID_BITS))
        else $error("id counter beyond limit");

    // Every insertion without a concurrent start_id write consumes exactly one id.
    a_insert_id: assert property (@(posedge aclk) disable iff (!aresetn)
        insert && !cfg_we |=> nfid_reg == $past(nfid_reg) + NFID_W'(1))
        else $error("insertion did not advance the id counter");

    // The clearing pass only writes invalid entries.
    a_clear_word: assert property (@(posedge aclk) disable iff (!aresetn)
        ram_we && (state_reg == ST_CLEAR) |-> !ram_wdata[WORD_W-1])
        else $error("clearing pass wrote a valid entry");

    // A final result is only loaded from the emission state.
    a_last_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) && m_tlast_reg |-> $past(state_reg) == ST_EMIT)
        else $error("result loaded outside emission");

endmodule

`default_nettype wire
